>>> rtl/ipsd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ips patch stream decoder
// no dependencies

package ipsd_pkg;

	localparam int unsigned AddrW = 25;
	localparam int unsigned RunW  = 16;

	// result queue depth, a power of two so the pointers wrap on their own
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FILL  = 2'd1;
	localparam logic [1:0] OP_DONE  = 2'd2;
	localparam logic [1:0] OP_ERROR = 2'd3;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_HEADER  = 2'd1;
	localparam logic [1:0] ERR_CORRUPT = 2'd2;

	localparam logic [23:0] EOF_MARK = 24'h454f46;

	localparam logic [2:0] REG_APPLY_MODE  = 3'd0;
	localparam logic [2:0] REG_TARGET_SIZE = 3'd4;

	typedef struct packed {
		logic [1:0]       op_kind;
		logic [AddrW-1:0] target_address;
		logic [7:0]       byte_value;
		logic [RunW-1:0]  run_length;
		logic [1:0]       error_code;
		logic [AddrW-1:0] extent_reached;
	} result_t;

	// expected header text, one character per index
	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h50;
			3'd1: c = 8'h41;
			3'd2: c = 8'h54;
			3'd3: c = 8'h43;
			3'd4: c = 8'h48;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/ips_patch_stream_decoder.sv
`timescale 1ns / 1ps
// top level of the ips patch stream decoder: apb registers, parser and result queue
// depends on ipsd_pkg, ipsd_parser, ipsd_queue

// One patch byte is taken every clock while full is low; each byte is parsed in
// the cycle it is accepted and gives at most one result transaction, which waits
// in a four-entry result queue. The queue alone sets the rate: the input stalls
// only when four results are waiting to be popped. When no older result is
// waiting, a result is visible on the output ports the cycle after its byte was
// accepted. Configuration (apply_mode at address 0, target_size at address 4)
// must be written only between streams.

module ips_patch_stream_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 patch_byte,
	input  logic                       last_byte,
	output logic                       empty,
	input  logic                       pop,
	output logic [1:0]                 op_kind,
	output logic [ipsd_pkg::AddrW-1:0] target_address,
	output logic [7:0]                 byte_value,
	output logic [ipsd_pkg::RunW-1:0]  run_length,
	output logic [1:0]                 error_code,
	output logic [ipsd_pkg::AddrW-1:0] extent_reached
);
	import ipsd_pkg::*;

	logic             apply_mode_q;
	logic [AddrW-1:0] target_size_q;
	logic             cfg_wr;
	logic             accept;
	logic             res_valid;
	result_t          res;
	result_t          head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apply_mode_q  <= 1'b0;
			target_size_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TARGET_SIZE[2])
				target_size_q <= pwdata[AddrW-1:0];
			else
				apply_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_TARGET_SIZE[2])
			prdata = {{(32-AddrW){1'b0}}, target_size_q};
		else
			prdata = {31'd0, apply_mode_q};
	end

	assign accept = push && !full;

	ipsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (accept),
		.patch_byte (patch_byte),
		.last_byte  (last_byte),
		.apply_mode (apply_mode_q),
		.target_size(target_size_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	ipsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && res_valid),
		.wr_data(res),
		.full   (full),
		.rd_en  (pop),
		.empty  (empty),
		.rd_data(head)
	);

	assign op_kind        = head.op_kind;
	assign target_address = head.target_address;
	assign byte_value     = head.byte_value;
	assign run_length     = head.run_length;
	assign error_code     = head.error_code;
	assign extent_reached = head.extent_reached;

endmodule

>>> rtl/ipsd_parser.sv
`timescale 1ns / 1ps
// front end: parses patch bytes and builds result transactions
// depends on ipsd_pkg

module ipsd_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	input  logic [7:0]               patch_byte,
	input  logic                     last_byte,
	input  logic                     apply_mode,
	input  logic [ipsd_pkg::AddrW-1:0] target_size,
	output logic                     res_valid,
	output ipsd_pkg::result_t        res
);
	import ipsd_pkg::*;

	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_ADDR0  = 4'd1;
	localparam logic [3:0] PH_ADDR1  = 4'd2;
	localparam logic [3:0] PH_ADDR2  = 4'd3;
	localparam logic [3:0] PH_LEN0   = 4'd4;
	localparam logic [3:0] PH_LEN1   = 4'd5;
	localparam logic [3:0] PH_DATA   = 4'd6;
	localparam logic [3:0] PH_RUN0   = 4'd7;
	localparam logic [3:0] PH_RUN1   = 4'd8;
	localparam logic [3:0] PH_VALUE  = 4'd9;
	localparam logic [3:0] PH_SKIP   = 4'd10;

	logic [3:0]       phase_q, phase_d;
	logic [2:0]       hidx_q, hidx_d;
	logic [23:0]      raddr_q, raddr_d;
	logic [15:0]      rlen_q, rlen_d;
	logic [15:0]      didx_q, didx_d;
	logic [AddrW-1:0] ext_q, ext_d;
	logic             clear;

	logic [15:0]      len_full;
	logic [15:0]      didx_inc;
	logic [AddrW-1:0] span_end;
	logic [AddrW-1:0] rec_end;
	logic             over;
	logic [1:0]       trunc_code;

	assign len_full   = {rlen_q[15:8], patch_byte};
	assign didx_inc   = didx_q + 16'd1;
	assign span_end   = {1'b0, raddr_q} + {{(AddrW-16){1'b0}}, len_full};
	assign rec_end    = {1'b0, raddr_q} + {{(AddrW-16){1'b0}}, rlen_q};
	assign over       = apply_mode && (span_end > target_size);
	assign trunc_code = (hidx_q == 3'd5) ? ERR_HEADER : ERR_CORRUPT;

	always_comb begin
		phase_d   = phase_q;
		hidx_d    = hidx_q;
		raddr_d   = raddr_q;
		rlen_d    = rlen_q;
		didx_d    = didx_q;
		ext_d     = ext_q;
		clear     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_HEADER: begin
				if (hidx_q > 3'd4 || patch_byte != magic_char(hidx_q) || last_byte) begin
					res_valid      = 1'b1;
					res.op_kind    = OP_ERROR;
					res.error_code = ERR_HEADER;
					phase_d        = PH_SKIP;
				end else begin
					hidx_d = hidx_q + 3'd1;
					if (hidx_q == 3'd4)
						phase_d = PH_ADDR0;
				end
			end
			PH_ADDR0, PH_ADDR1: begin
				if (last_byte) begin
					res_valid      = 1'b1;
					res.op_kind    = OP_ERROR;
					res.error_code = trunc_code;
				end else if (phase_q == PH_ADDR0) begin
					raddr_d = {patch_byte, 16'h0000};
					phase_d = PH_ADDR1;
				end else begin
					raddr_d = {raddr_q[23:16], patch_byte, 8'h00};
					phase_d = PH_ADDR2;
				end
			end
			PH_ADDR2: begin
				raddr_d = {raddr_q[23:8], patch_byte};
				hidx_d  = 3'd6;
				phase_d = PH_LEN0;
				if (last_byte) begin
					res_valid = 1'b1;
					if ({raddr_q[23:8], patch_byte} == EOF_MARK) begin
						res.op_kind = OP_DONE;
					end else begin
						res.op_kind    = OP_ERROR;
						res.error_code = ERR_CORRUPT;
					end
				end
			end
			PH_LEN0, PH_RUN0: begin
				if (last_byte) begin
					res_valid      = 1'b1;
					res.op_kind    = OP_ERROR;
					res.error_code = ERR_CORRUPT;
				end else begin
					rlen_d  = {patch_byte, 8'h00};
					phase_d = (phase_q == PH_LEN0) ? PH_LEN1 : PH_RUN1;
				end
			end
			PH_LEN1, PH_RUN1: begin
				rlen_d = len_full;
				if (last_byte) begin
					res_valid      = 1'b1;
					res.op_kind    = OP_ERROR;
					res.error_code = ERR_CORRUPT;
				end else if (phase_q == PH_LEN1 && len_full == 16'd0) begin
					phase_d = PH_RUN0;
				end else if (over) begin
					res_valid      = 1'b1;
					res.op_kind    = OP_ERROR;
					res.error_code = ERR_CORRUPT;
					phase_d        = PH_SKIP;
				end else begin
					didx_d  = 16'd0;
					phase_d = (phase_q == PH_LEN1) ? PH_DATA : PH_VALUE;
				end
			end
			PH_DATA: begin
				didx_d = didx_inc;
				if (didx_inc == rlen_q) begin
					if (rec_end > ext_q)
						ext_d = rec_end;
					phase_d = PH_ADDR0;
				end
				res.target_address = {1'b0, raddr_q} + {{(AddrW-16){1'b0}}, didx_q};
				res.byte_value     = patch_byte;
				res.op_kind        = OP_WRITE;
				res_valid          = apply_mode;
				if (last_byte) begin
					res                = '0;
					res.op_kind        = OP_ERROR;
					res.error_code     = ERR_CORRUPT;
					res_valid          = 1'b1;
				end
			end
			PH_VALUE: begin
				if (rec_end > ext_q)
					ext_d = rec_end;
				phase_d            = PH_ADDR0;
				res.op_kind        = OP_FILL;
				res.target_address = {1'b0, raddr_q};
				res.byte_value     = patch_byte;
				res.run_length     = rlen_q;
				res_valid          = apply_mode;
				if (last_byte) begin
					res            = '0;
					res.op_kind    = OP_ERROR;
					res.error_code = ERR_CORRUPT;
					res_valid      = 1'b1;
				end
			end
			default: begin
				phase_d = PH_SKIP;
			end
		endcase
		res.extent_reached = ext_d;
		// a transaction with the final byte always closes the stream
		if (last_byte)
			clear = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q  <= '0;
			raddr_q <= '0;
			rlen_q  <= '0;
			didx_q  <= '0;
			ext_q   <= '0;
		end else if (byte_valid) begin
			if (clear) begin
				phase_q <= PH_HEADER;
				hidx_q  <= '0;
				raddr_q <= '0;
				rlen_q  <= '0;
				didx_q  <= '0;
				ext_q   <= '0;
			end else begin
				phase_q <= phase_d;
				hidx_q  <= hidx_d;
				raddr_q <= raddr_d;
				rlen_q  <= rlen_d;
				didx_q  <= didx_d;
				ext_q   <= ext_d;
			end
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && last_byte |=> phase_q == PH_HEADER && ext_q == '0)
		else $error("final byte did not restart the parser");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> !res_valid || last_byte)
		else $error("result raised while skipping");

	a_extent_grows: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !last_byte |=> ext_q >= $past(ext_q))
		else $error("extent went down inside a stream");

	a_header_index: assert property (@(posedge clk) disable iff (!arst_n)
		hidx_q <= 3'd6)
		else $error("header index out of range");

endmodule

>>> rtl/ipsd_queue.sv
`timescale 1ns / 1ps
// back end: result queue that holds decoded transactions until they are popped
// depends on ipsd_pkg

module ipsd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ipsd_pkg::result_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic              empty,
	output ipsd_pkg::result_t rd_data
);
	import ipsd_pkg::*;

	result_t          mem_q [QDepth];
	logic [QPtrW-1:0] wptr_q;
	logic [QPtrW-1:0] rptr_q;
	logic [QPtrW:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = count_q == (QPtrW+1)'(QDepth);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + QPtrW'(1);
			if (do_rd)
				rptr_q <= rptr_q + QPtrW'(1);
			count_q <= count_q + (QPtrW+1)'(do_wr) - (QPtrW+1)'(do_rd);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPtrW+1)'(QDepth))
		else $error("queue count overflow");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q == rptr_q + count_q[QPtrW-1:0])
		else $error("queue pointers disagree with count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + (QPtrW+1)'(1))
		else $error("write not counted");

endmodule
